FILE: design/bipartite_matching_engine_top_macros.svh
// Assertion macros for the matching engine checker.
// Needs signals named clock and reset in the scope of use.
`ifndef BIPARTITE_MATCHING_ENGINE_TOP_MACROS_SVH
`define BIPARTITE_MATCHING_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define BME_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BME_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bme_pkg.sv
// Shared types and constants for the bipartite matching engine.
// No dependencies.
`default_nettype none
package bme_pkg;
   localparam int MASK_BITS       = 10;
   localparam int LABEL_W         = 5;
   localparam int COPIES_W        = 4;
   localparam int SERVER_W        = 4;
   localparam int LISTED_W        = $clog2(MASK_BITS + 1);
   localparam int NUM_SERVERS_DEF = 10;
   localparam int MAX_JOBS_DEF    = 10;
   localparam int GRP_DEPTH       = 2;
   localparam int RSP_DEPTH       = 2;

   typedef struct packed {
      logic [LABEL_W-1:0]   job_label;
      logic [COPIES_W-1:0]  copies;
      logic [MASK_BITS-1:0] allowed_mask;
      logic                 last_group;
      logic                 short_mask;   // more copies than usable servers
   } group_type;

   typedef struct packed {
      logic                feasible;
      logic [SERVER_W-1:0] server;
      logic                occupied;
      logic [LABEL_W-1:0]  owner_label;
      logic                last_result;
   } result_type;
endpackage
`default_nettype wire

FILE: design/bipartite_matching_engine_top.sv
// Job-to-server matching engine. Groups enter through a push/full queue, one
// group per cycle while the group queue has room; each copy of a group becomes
// one job row. On the last group the back end runs a greedy pass over the rows
// and then a depth-first augmenting search per unmatched row, one stack
// step per cycle; each step skips straight to the next allowed server, and the
// rows of the found path are then committed one by one. Results leave through
// an empty/pop queue: one per server when all rows match, else a single
// infeasible result. The search sequencer is the limit: one augmenting search
// is repeated for each row that the greedy pass leaves unmatched. Depends on
// bme_pkg, bme_queue, bme_front, bme_back.
`default_nettype none
module bipartite_matching_engine_top
   import bme_pkg::*;
#(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF,
   parameter int MAX_JOBS    = MAX_JOBS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [LABEL_W-1:0]   req_job_label,
   input  logic [COPIES_W-1:0]  req_copies,
   input  logic [MASK_BITS-1:0] req_allowed_mask,
   input  logic                 req_last_group,
   output logic                 empty,
   input  logic                 pop,
   output logic                 rsp_feasible,
   output logic [SERVER_W-1:0]  rsp_server,
   output logic                 rsp_occupied,
   output logic [LABEL_W-1:0]   rsp_owner_label,
   output logic                 rsp_last_result
);
   group_type  grp;
   logic       grp_valid, grp_pop;
   result_type rsp_wr, rsp_rd;
   logic       rsp_push, rsp_full;

   bme_front #(
      .NUM_SERVERS (NUM_SERVERS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .job_label    (req_job_label),
      .copies       (req_copies),
      .allowed_mask (req_allowed_mask),
      .last_group   (req_last_group),
      .grp_pop      (grp_pop),
      .grp_valid    (grp_valid),
      .grp          (grp)
   );

   bme_back #(
      .NUM_SERVERS (NUM_SERVERS),
      .MAX_JOBS    (MAX_JOBS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (grp_valid),
      .grp       (grp),
      .grp_pop   (grp_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   bme_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (rsp_rd),
      .empty   (empty)
   );

   assign rsp_feasible    = rsp_rd.feasible;
   assign rsp_server      = rsp_rd.server;
   assign rsp_occupied    = rsp_rd.occupied;
   assign rsp_owner_label = rsp_rd.owner_label;
   assign rsp_last_result = rsp_rd.last_result;
endmodule
`default_nettype wire

FILE: design/bme_queue.sv
// Small register FIFO with push/full and pop/empty sides.
// Stand-alone, used for the group queue and the result queue.
`default_nettype none
module bme_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] mem_in [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         mem_in[wr_ptr_ff] = wr_data;
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/bme_front.sv
// Input side: trims the server mask, checks copies against usable servers
// and queues the group. Depends on bme_pkg and bme_queue.
`default_nettype none
module bme_front
   import bme_pkg::*;
#(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [LABEL_W-1:0]   job_label,
   input  logic [COPIES_W-1:0]  copies,
   input  logic [MASK_BITS-1:0] allowed_mask,
   input  logic                 last_group,
   input  logic                 grp_pop,
   output logic                 grp_valid,
   output group_type            grp
);
   logic [MASK_BITS-1:0] usable;
   logic [LISTED_W-1:0]  listed;
   group_type            grp_wr;
   logic                 grp_empty;

   always_comb begin
      usable = '0;
      listed = '0;
      for (int i = 0; i < MASK_BITS; i++) begin
         if (i < NUM_SERVERS) begin
            usable[i] = allowed_mask[i];
         end
         listed = listed + LISTED_W'(usable[i]);
      end
   end

   always_comb begin
      grp_wr.job_label    = job_label;
      grp_wr.copies       = copies;
      grp_wr.allowed_mask = usable;
      grp_wr.last_group   = last_group;
      grp_wr.short_mask   = (LISTED_W'(copies) > listed);
   end

   assign grp_valid = ~grp_empty;

   bme_queue #(
      .WIDTH ($bits(group_type)),
      .DEPTH (GRP_DEPTH)
   ) u_grp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (grp_wr),
      .full    (full),
      .pop     (grp_pop),
      .rd_data (grp),
      .empty   (grp_empty)
   );
endmodule
`default_nettype wire

FILE: design/bme_back.sv
// Back end: stores job rows, runs greedy pass plus augmenting-path search
// with an explicit stack, and emits results. Depends on bme_pkg.
`default_nettype none
module bme_back
   import bme_pkg::*;
#(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF,
   parameter int MAX_JOBS    = MAX_JOBS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       grp_valid,
   input  group_type  grp,
   output logic       grp_pop,
   input  logic       rsp_full,
   output logic       rsp_push,
   output result_type rsp
);
   localparam int ROW_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int SRV_W = $clog2(NUM_SERVERS);
   localparam int SV_W  = $clog2(NUM_SERVERS + 1);
   localparam int SUM_W = ((CNT_W > COPIES_W) ? CNT_W : COPIES_W) + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_GREEDY = 3'd1;
   localparam logic [2:0] ST_AUG    = 3'd2;
   localparam logic [2:0] ST_SEARCH = 3'd3;
   localparam logic [2:0] ST_BIND   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;
   localparam logic [2:0] ST_FAIL   = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [MASK_BITS-1:0]   row_allowed_ff [MAX_JOBS];
   logic [MASK_BITS-1:0]   row_allowed_in [MAX_JOBS];
   logic [LABEL_W-1:0]     row_label_ff [MAX_JOBS];
   logic [LABEL_W-1:0]     row_label_in [MAX_JOBS];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [NUM_SERVERS-1:0] busy_ff, busy_in;
   logic [ROW_W-1:0]       owner_ff [NUM_SERVERS];
   logic [ROW_W-1:0]       owner_in [NUM_SERVERS];
   logic [MAX_JOBS-1:0]    matched_ff, matched_in;
   logic [MAX_JOBS-1:0]    visited_ff, visited_in;
   logic [ROW_W-1:0]       stk_row_ff [MAX_JOBS];
   logic [ROW_W-1:0]       stk_row_in [MAX_JOBS];
   logic [SV_W-1:0]        stk_srv_ff [MAX_JOBS];
   logic [SV_W-1:0]        stk_srv_in [MAX_JOBS];
   logic [CNT_W-1:0]       depth_ff, depth_in;
   logic [CNT_W-1:0]       row_ff, row_in;
   logic [ROW_W-1:0]       k_ff, k_in;
   logic [SRV_W-1:0]       emit_ff, emit_in;

   logic [SUM_W-1:0]       fill_end;
   logic                   too_many;
   logic [ROW_W-1:0]       cur_row;
   logic [MASK_BITS-1:0]   g_mask;
   logic                   g_found;
   logic [SRV_W-1:0]       g_idx;
   logic [CNT_W-1:0]       depth_dec;
   logic [ROW_W-1:0]       top_idx;
   logic [ROW_W-1:0]       s_row;
   logic [SV_W-1:0]        s_start;
   logic [MASK_BITS-1:0]   s_mask;
   logic                   s_found;
   logic [SRV_W-1:0]       s_idx;
   logic [ROW_W-1:0]       s_owner;
   logic [SRV_W-1:0]       b_srv;
   logic [ROW_W-1:0]       b_row;
   logic                   emit_last;

   assign fill_end  = SUM_W'(count_ff) + SUM_W'(grp.copies);
   assign too_many  = (fill_end > SUM_W'(MAX_JOBS));
   assign cur_row   = row_ff[ROW_W-1:0];
   assign g_mask    = row_allowed_ff[cur_row];
   assign depth_dec = depth_ff - 1'b1;
   assign top_idx   = depth_dec[ROW_W-1:0];
   assign s_row     = stk_row_ff[top_idx];
   assign s_start   = stk_srv_ff[top_idx];
   assign s_mask    = row_allowed_ff[s_row];
   assign s_owner   = owner_ff[s_idx];
   assign b_srv     = stk_srv_ff[k_ff][SRV_W-1:0];
   assign b_row     = stk_row_ff[k_ff];
   assign emit_last = (emit_ff == SRV_W'(NUM_SERVERS - 1));

   // lowest allowed free server for the greedy pass
   always_comb begin
      g_found = 1'b0;
      g_idx   = '0;
      for (int i = MASK_BITS - 1; i >= 0; i--) begin
         if (i < NUM_SERVERS) begin
            if (g_mask[i] && !busy_ff[SRV_W'(i)]) begin
               g_found = 1'b1;
               g_idx   = SRV_W'(i);
            end
         end
      end
   end

   // lowest allowed server at or above the top frame's cursor
   always_comb begin
      s_found = 1'b0;
      s_idx   = '0;
      for (int i = MASK_BITS - 1; i >= 0; i--) begin
         if (i < NUM_SERVERS) begin
            if (s_mask[i] && SV_W'(i) >= s_start) begin
               s_found = 1'b1;
               s_idx   = SRV_W'(i);
            end
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      row_allowed_in = row_allowed_ff;
      row_label_in   = row_label_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      busy_in        = busy_ff;
      owner_in       = owner_ff;
      matched_in     = matched_ff;
      visited_in     = visited_ff;
      stk_row_in     = stk_row_ff;
      stk_srv_in     = stk_srv_ff;
      depth_in       = depth_ff;
      row_in         = row_ff;
      k_in           = k_ff;
      emit_in        = emit_ff;
      grp_pop        = 1'b0;
      rsp_push       = 1'b0;
      rsp            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (grp_valid) begin
               grp_pop = 1'b1;
               for (int i = 0; i < MAX_JOBS; i++) begin
                  if (SUM_W'(i) >= SUM_W'(count_ff) && SUM_W'(i) < fill_end) begin
                     row_allowed_in[i] = grp.allowed_mask;
                     row_label_in[i]   = grp.job_label;
                  end
               end
               count_in = too_many ? CNT_W'(MAX_JOBS) : CNT_W'(fill_end);
               ovf_in   = ovf_ff | too_many | grp.short_mask;
               if (grp.last_group) begin
                  row_in   = '0;
                  state_in = ovf_in ? ST_FAIL : ST_GREEDY;
               end
            end
         end
         ST_GREEDY: begin
            if (row_ff == count_ff) begin
               row_in   = '0;
               state_in = ST_AUG;
            end else begin
               if (!matched_ff[cur_row] && g_found) begin
                  busy_in[g_idx]      = 1'b1;
                  owner_in[g_idx]     = cur_row;
                  matched_in[cur_row] = 1'b1;
               end
               row_in = row_ff + 1'b1;
            end
         end
         ST_AUG: begin
            if (row_ff == count_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end else if (matched_ff[cur_row]) begin
               row_in = row_ff + 1'b1;
            end else begin
               stk_row_in[0]       = cur_row;
               stk_srv_in[0]       = '0;
               visited_in          = '0;
               visited_in[cur_row] = 1'b1;
               depth_in            = CNT_W'(1);
               state_in            = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!s_found) begin
               // dead end: pop frame and advance parent's cursor
               depth_in = depth_dec;
               if (depth_dec == '0) begin
                  state_in = ST_FAIL;
               end else begin
                  stk_srv_in[top_idx - 1'b1] = stk_srv_ff[top_idx - 1'b1] + 1'b1;
               end
            end else begin
               stk_srv_in[top_idx] = SV_W'(s_idx);
               if (!busy_ff[s_idx]) begin
                  k_in     = top_idx;
                  state_in = ST_BIND;
               end else if (visited_ff[s_owner] || depth_ff >= CNT_W'(MAX_JOBS)) begin
                  stk_srv_in[top_idx] = SV_W'(s_idx) + 1'b1;
               end else begin
                  visited_in[s_owner]              = 1'b1;
                  stk_row_in[depth_ff[ROW_W-1:0]] = s_owner;
                  stk_srv_in[depth_ff[ROW_W-1:0]] = '0;
                  depth_in                         = depth_ff + 1'b1;
               end
            end
         end
         ST_BIND: begin
            busy_in[b_srv]    = 1'b1;
            owner_in[b_srv]   = b_row;
            matched_in[b_row] = 1'b1;
            if (k_ff == '0) begin
               row_in   = row_ff + 1'b1;
               state_in = ST_AUG;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            rsp.feasible    = 1'b1;
            rsp.server      = SERVER_W'(emit_ff);
            rsp.occupied    = busy_ff[emit_ff];
            rsp.owner_label = busy_ff[emit_ff] ? row_label_ff[owner_ff[emit_ff]] : '0;
            rsp.last_result = emit_last;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (emit_last) begin
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  busy_in    = '0;
                  matched_in = '0;
                  visited_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         ST_FAIL: begin
            rsp.last_result = 1'b1;
            if (!rsp_full) begin
               rsp_push   = 1'b1;
               count_in   = '0;
               ovf_in     = 1'b0;
               busy_in    = '0;
               matched_in = '0;
               visited_in = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      row_allowed_ff <= row_allowed_in;
      row_label_ff   <= row_label_in;
      owner_ff       <= owner_in;
      stk_row_ff     <= stk_row_in;
      stk_srv_ff     <= stk_srv_in;
      depth_ff       <= depth_in;
      row_ff         <= row_in;
      k_ff           <= k_in;
      emit_ff        <= emit_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         busy_ff    <= '0;
         matched_ff <= '0;
         visited_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         busy_ff    <= busy_in;
         matched_ff <= matched_in;
         visited_ff <= visited_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/bme_checker.sv
// Port-level checks on the result side of the matching engine, and the bind
// that attaches them. Depends on bme_pkg and the assertion macro header.
`default_nettype none
`include "bipartite_matching_engine_top_macros.svh"
module bme_checker
   import bme_pkg::*;
#(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                empty,
   input logic                pop,
   input logic                rsp_feasible,
   input logic [SERVER_W-1:0] rsp_server,
   input logic                rsp_occupied,
   input logic [LABEL_W-1:0]  rsp_owner_label,
   input logic                rsp_last_result
);
   `BME_ASSERT_NOW(a_infeasible_form, !empty && !rsp_feasible, rsp_last_result && rsp_server == '0 && !rsp_occupied, "infeasible result malformed")
   `BME_ASSERT_NOW(a_empty_label, !empty && !rsp_occupied, rsp_owner_label == '0, "label on empty server")
   `BME_ASSERT_NOW(a_last_server, !empty && rsp_feasible, rsp_last_result == (rsp_server == SERVER_W'(NUM_SERVERS - 1)), "last flag off final server")
   `BME_ASSERT_NEXT(a_hold, !empty && !pop, !empty, "result dropped without transfer")
endmodule

bind bipartite_matching_engine_top bme_checker #(
   .NUM_SERVERS (NUM_SERVERS)
) u_bme_checker (
   .clock           (clock),
   .reset           (reset),
   .empty           (empty),
   .pop             (pop),
   .rsp_feasible    (rsp_feasible),
   .rsp_server      (rsp_server),
   .rsp_occupied    (rsp_occupied),
   .rsp_owner_label (rsp_owner_label),
   .rsp_last_result (rsp_last_result)
);
`default_nettype wire
